### sv/assert_macros.svh
// Assertion macros used by the parser's top-level RTL file.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HGP_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define HGP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HGP_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define HGP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

### sv/hgp_pkg.sv
// Types, codes and character tables for the HTTP GET request parser.
// Depends on nothing; imported by every parser module.
package hgp_pkg;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_GET  = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      POS_METHOD  = 3'd0,
      POS_GAP1    = 3'd1,
      POS_URL     = 3'd2,
      POS_GAP2    = 3'd3,
      POS_VERSION = 3'd4,
      POS_DEAD    = 3'd5
   } field_pos_type;

   typedef enum logic [1:0] {
      URL_UNDECIDED = 2'd0,
      URL_OK        = 2'd1,
      URL_PREFIX    = 2'd2,
      URL_BAD       = 2'd3
   } url_mode_type;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_LOW_H = 8'h68;

   localparam logic [3:0] METHOD_LEN  = 4'd3;
   localparam logic [3:0] SCHEME_LEN  = 4'd7;
   localparam logic [3:0] VERSION_LEN = 4'd8;

   typedef struct packed {
      logic          phase;
      status_type    final_status;
      logic          cr_pending;
      field_pos_type field_position;
      logic [3:0]    match_count;
      logic          field_mismatch;
      url_mode_type  url_mode;
      logic          line_is_empty;
      logic          line_cut;
   } parse_state_type;

   typedef struct packed {
      status_type status;
      logic       line_done;
   } result_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return 8'(c + 8'd32);
      end
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB);
   endfunction

   function automatic logic [7:0] method_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return 8'h67;
         4'd1:    return 8'h65;
         4'd2:    return 8'h74;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] scheme_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return 8'h68;
         4'd1:    return 8'h74;
         4'd2:    return 8'h74;
         4'd3:    return 8'h70;
         4'd4:    return 8'h3A;
         4'd5:    return 8'h2F;
         4'd6:    return 8'h2F;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] version_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return 8'h68;
         4'd1:    return 8'h74;
         4'd2:    return 8'h74;
         4'd3:    return 8'h70;
         4'd4:    return 8'h2F;
         4'd5:    return 8'h31;
         4'd6:    return 8'h2E;
         4'd7:    return 8'h31;
         default: return 8'h00;
      endcase
   endfunction

endpackage

### sv/http_get_request_parser.sv
// Top level of the HTTP GET request parser: parse state registers and channels.
// Depends on hgp_pkg, hgp_step, hgp_out_fifo and assert_macros.svh.
//
// The request channel carries one byte per transfer in req_tdata; req_tuser high
// restarts the parser for a new request and its data byte is ignored. Every
// request transfer yields exactly one result transfer: rsp_tdata holds the
// status (need more bytes, complete GET request, bad request) and rsp_tlast is
// high when that byte was the LF closing a CR LF line.
// One byte is taken every cycle while the result buffer has room. The parse
// state is updated and the result is written into the buffer at the transfer edge.
// Results wait in a two-entry buffer; while the receiver stalls the block keeps
// taking bytes until both entries are full, and then holds req_tready low.
// Synchronous reset returns the parser to the start of a request line with a
// pending status and empties the result buffer.
`include "assert_macros.svh"
module http_get_request_parser import hgp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tuser,  // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [1:0] status, [7:2] zero
   output logic       rsp_tlast   // line_done
);

   parse_state_type state_ff, state_in;
   result_type      step_result;
   result_type      rsp_result;
   logic            can_push;
   logic            in_fire;

   assign req_tready = can_push;
   assign in_fire    = req_tvalid && req_tready;

   hgp_step u_step (
      .cur       (state_ff),
      .restart   (req_tuser),
      .data_byte (req_tdata),
      .nxt       (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= 1'b0;
         state_ff.final_status   <= ST_MORE;
         state_ff.cr_pending     <= 1'b0;
         state_ff.field_position <= POS_METHOD;
         state_ff.match_count    <= 4'd0;
         state_ff.field_mismatch <= 1'b0;
         state_ff.url_mode       <= URL_UNDECIDED;
         state_ff.line_is_empty  <= 1'b1;
         state_ff.line_cut       <= 1'b0;
      end else if (in_fire) begin
         state_ff <= state_in;
      end
   end

   hgp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire),
      .push_data (step_result),
      .can_push  (can_push),
      .pop_valid (rsp_tvalid),
      .pop_data  (rsp_result),
      .pop       (rsp_tready)
   );

   assign rsp_tdata = {6'd0, rsp_result.status};
   assign rsp_tlast = rsp_result.line_done;

   `HGP_ASSERT_NEXT(a_final_sticky, clock, reset, in_fire && !req_tuser && state_ff.final_status != ST_MORE, $stable(state_ff.final_status), "final status changed without a restart")
   `HGP_ASSERT_IMPLY(a_cr_only_pending, clock, reset, state_ff.cr_pending, state_ff.final_status == ST_MORE, "CR pending after a final status")
   `HGP_ASSERT_NEXT(a_restart_clears, clock, reset, in_fire && req_tuser, !state_ff.phase && state_ff.final_status == ST_MORE && !state_ff.cr_pending, "restart did not clear the parser")

endmodule

### sv/hgp_step.sv
// Next-state and result logic of the parser for one transfer.
// Depends on hgp_pkg; purely combinational.
module hgp_step import hgp_pkg::*; (
   input  parse_state_type cur,
   input  logic            restart,
   input  logic [7:0]      data_byte,
   output parse_state_type nxt,
   output result_type      result
);

   always_comb begin
      logic [7:0]   lc;
      logic [3:0]   mc;
      url_mode_type um;
      logic         done;

      nxt  = cur;
      done = 1'b0;
      lc   = fold_case(data_byte);
      mc   = cur.match_count;
      um   = cur.url_mode;

      if (restart) begin
         nxt.phase          = 1'b0;
         nxt.final_status   = ST_MORE;
         nxt.cr_pending     = 1'b0;
         nxt.field_position = POS_METHOD;
         nxt.match_count    = 4'd0;
         nxt.field_mismatch = 1'b0;
         nxt.url_mode       = URL_UNDECIDED;
         nxt.line_is_empty  = 1'b1;
         nxt.line_cut       = 1'b0;
      end else if (cur.final_status == ST_MORE) begin
         if (cur.cr_pending) begin
            nxt.cr_pending = 1'b0;
            if (data_byte == CHR_LF) begin
               done = 1'b1;
               if (!cur.phase) begin
                  if (cur.field_position == POS_VERSION && cur.match_count == VERSION_LEN
                      && !cur.field_mismatch) begin
                     nxt.phase = 1'b1;
                  end else begin
                     nxt.final_status = ST_BAD;
                  end
               end else if (cur.line_is_empty) begin
                  nxt.final_status = ST_GET;
               end
               nxt.field_position = POS_METHOD;
               nxt.match_count    = 4'd0;
               nxt.field_mismatch = 1'b0;
               nxt.url_mode       = URL_UNDECIDED;
               nxt.line_is_empty  = 1'b1;
               nxt.line_cut       = 1'b0;
            end else begin
               nxt.final_status = ST_BAD;
            end
         end else if (data_byte == CHR_CR) begin
            nxt.cr_pending = 1'b1;
         end else if (data_byte == CHR_LF) begin
            nxt.final_status = ST_BAD;
         end else if (!cur.line_cut) begin
            if (data_byte == CHR_NUL) begin
               nxt.line_cut = 1'b1;
            end else begin
               nxt.line_is_empty = 1'b0;
               if (!cur.phase) begin
                  if (cur.field_position == POS_GAP1) begin
                     mc = 4'd0;
                     um = URL_UNDECIDED;
                  end
                  if (cur.field_position == POS_GAP2) begin
                     mc = 4'd0;
                  end
                  unique case (cur.field_position)
                     POS_METHOD: begin
                        if (is_blank(data_byte)) begin
                           nxt.field_position = (mc == METHOD_LEN && !cur.field_mismatch)
                                                ? POS_GAP1 : POS_DEAD;
                        end else if (mc < METHOD_LEN && lc == method_char(mc)) begin
                           nxt.match_count = 4'(mc + 4'd1);
                        end else begin
                           nxt.field_mismatch = 1'b1;
                        end
                     end
                     POS_GAP1, POS_URL: begin
                        if (cur.field_position == POS_URL && is_blank(data_byte)) begin
                           nxt.field_position = (um == URL_OK) ? POS_GAP2 : POS_DEAD;
                        end else if (!is_blank(data_byte)) begin
                           nxt.field_position = POS_URL;
                           nxt.match_count    = mc;
                           nxt.url_mode       = um;
                           if (um == URL_UNDECIDED) begin
                              if (data_byte == CHR_SLASH) begin
                                 nxt.url_mode = URL_OK;
                              end else if (lc == CHR_LOW_H) begin
                                 nxt.url_mode    = URL_PREFIX;
                                 nxt.match_count = 4'd1;
                              end else begin
                                 nxt.url_mode = URL_BAD;
                              end
                           end else if (um == URL_PREFIX) begin
                              if (mc < SCHEME_LEN) begin
                                 if (lc == scheme_char(mc)) begin
                                    nxt.match_count = 4'(mc + 4'd1);
                                 end else begin
                                    nxt.url_mode = URL_BAD;
                                 end
                              end else if (data_byte == CHR_SLASH) begin
                                 nxt.url_mode = URL_OK;
                              end
                           end
                        end
                     end
                     POS_GAP2, POS_VERSION: begin
                        if (cur.field_position == POS_VERSION || !is_blank(data_byte)) begin
                           nxt.field_position = POS_VERSION;
                           nxt.match_count    = mc;
                           if (cur.field_position == POS_GAP2) begin
                              nxt.field_mismatch = 1'b0;
                           end
                           if (mc < VERSION_LEN && lc == version_char(mc)) begin
                              nxt.match_count = 4'(mc + 4'd1);
                           end else begin
                              nxt.field_mismatch = 1'b1;
                           end
                        end
                     end
                     POS_DEAD: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end

      result.status    = nxt.final_status;
      result.line_done = done;
   end

endmodule

### sv/hgp_out_fifo.sv
// Two-entry result buffer between the parser and the result channel.
// Depends on hgp_pkg for the result type.
module hgp_out_fifo import hgp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       can_push,
   output logic       pop_valid,
   output result_type pop_data,
   input  logic       pop
);

   result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign can_push  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
